/* hdl/led_blink_controller_core_assert.svh */
// Assertion helpers for the checker file.
`ifndef LED_BLINK_CONTROLLER_CORE_ASSERT_SVH
`define LED_BLINK_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, dropped while reset is high.
`define LBC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, dropped while reset is high.
`define LBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lbc_pkg.sv */
`timescale 1ns / 1ps

package lbc_pkg;

  typedef enum logic [3:0] {
    FUNC_TICK       = 4'd0,
    FUNC_ACTIVATE   = 4'd1,
    FUNC_DEACTIVATE = 4'd2,
    FUNC_ON         = 4'd3,
    FUNC_OFF        = 4'd4,
    FUNC_TOGGLE     = 4'd5,
    FUNC_SLOW       = 4'd6,
    FUNC_FAST       = 4'd7,
    FUNC_STOP       = 4'd8
  } func_t;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_OFF      = 2'd1,
    MODE_ON       = 2'd2,
    MODE_BLINK    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_ACTIVATE   = 3'd1,
    EV_DEACTIVATE = 3'd2,
    EV_ON         = 3'd3,
    EV_OFF        = 3'd4,
    EV_SLOW       = 3'd5,
    EV_FAST       = 3'd6,
    EV_END        = 3'd7
  } ev_kind_t;

  localparam logic REG_SLOW = 1'b0;
  localparam logic REG_FAST = 1'b1;

  localparam logic [15:0] SLOW_RESET = 16'd500;
  localparam logic [15:0] FAST_RESET = 16'd125;

  typedef struct packed {
    logic        led_level;
    mode_t       led_mode;
    ev_kind_t    event_kind;
    logic [14:0] event_data;
    logic        last;
  } result_t;

  // One accepted item yields first, and second as well when two is set.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } step_t;

endpackage

/* hdl/lbc_fsm.sv */
`timescale 1ns / 1ps

module lbc_fsm import lbc_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic [3:0]  func,
  input  logic        blink_finite,
  input  logic [14:0] blink_count,
  input  logic [15:0] slow_interval_ms,
  input  logic [15:0] fast_interval_ms,
  output step_t       step
);

  localparam int CmpW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  mode_t                 mode, mode_next;
  logic                  mode_before_blink, mode_before_blink_next;
  logic                  level, level_next;
  logic                  blink_fast, blink_fast_next;
  logic                  blink_is_finite, blink_is_finite_next;
  logic [COUNT_BITS-1:0] toggle_count, toggle_count_next;
  logic [14:0]           blink_target, blink_target_next;
  logic [15:0]           ticks_since_toggle, ticks_since_toggle_next;

  logic [15:0]     interval;
  logic [16:0]     tick_inc;
  logic [CmpW-1:0] tog_w;
  logic [CmpW-1:0] tgt_w;
  logic [CmpW-1:0] half_w;
  logic [14:0]     half;
  logic            end_hit;
  logic            go_fast;
  logic            go_on;
  mode_t           go_mode;
  ev_kind_t        kind;
  logic [14:0]     data;
  logic            two;

  assign interval = blink_fast ? fast_interval_ms : slow_interval_ms;
  assign tick_inc = {1'b0, ticks_since_toggle} + 17'd1;
  assign tog_w    = CmpW'(toggle_count);
  assign tgt_w    = CmpW'({blink_target, 1'b0});
  assign half_w   = tog_w >> 1;
  assign half     = half_w[14:0];
  assign end_hit  = blink_is_finite && (tog_w == tgt_w);
  assign go_fast  = (func_t'(func) == FUNC_FAST);
  assign go_on    = (func_t'(func) == FUNC_ON);
  assign go_mode  = go_on ? MODE_ON : MODE_OFF;

  always_comb begin
    mode_next               = mode;
    mode_before_blink_next  = mode_before_blink;
    level_next              = level;
    blink_fast_next         = blink_fast;
    blink_is_finite_next    = blink_is_finite;
    toggle_count_next       = toggle_count;
    blink_target_next       = blink_target;
    ticks_since_toggle_next = ticks_since_toggle;
    kind                    = EV_NONE;
    data                    = '0;
    two                     = 1'b0;

    unique case (func_t'(func))
      FUNC_TICK: begin
        if (mode == MODE_BLINK) begin
          if (tick_inc > {1'b0, interval}) begin
            if (end_hit) begin
              mode_next  = mode_before_blink ? MODE_ON : MODE_OFF;
              level_next = mode_before_blink;
              kind       = EV_END;
              data       = half;
            end else begin
              level_next              = ~level;
              toggle_count_next       = toggle_count + COUNT_BITS'(1);
              ticks_since_toggle_next = '0;
            end
          end else begin
            ticks_since_toggle_next = tick_inc[16] ? 16'hFFFF : tick_inc[15:0];
          end
        end
      end
      FUNC_ACTIVATE: begin
        if (mode == MODE_INACTIVE) begin
          mode_next  = MODE_OFF;
          level_next = 1'b0;
          kind       = EV_ACTIVATE;
        end
      end
      FUNC_DEACTIVATE: begin
        if (mode != MODE_INACTIVE) begin
          mode_next  = MODE_INACTIVE;
          level_next = 1'b0;
          kind       = EV_DEACTIVATE;
        end
      end
      FUNC_ON, FUNC_OFF: begin
        if (mode == MODE_BLINK) begin
          // end the blink first, then report the new level
          two        = 1'b1;
          mode_next  = go_mode;
          level_next = go_on;
          kind       = go_on ? EV_ON : EV_OFF;
        end else if (mode != MODE_INACTIVE && mode != go_mode) begin
          mode_next  = go_mode;
          level_next = go_on;
          kind       = go_on ? EV_ON : EV_OFF;
        end
      end
      FUNC_TOGGLE: begin
        if (mode == MODE_OFF) begin
          mode_next  = MODE_ON;
          level_next = 1'b1;
          kind       = EV_ON;
        end else if (mode == MODE_ON) begin
          mode_next  = MODE_OFF;
          level_next = 1'b0;
          kind       = EV_OFF;
        end
      end
      FUNC_SLOW, FUNC_FAST: begin
        if (mode == MODE_OFF || mode == MODE_ON) begin
          mode_before_blink_next  = (mode == MODE_ON);
          level_next              = 1'b0;
          blink_fast_next         = go_fast;
          blink_is_finite_next    = blink_finite;
          toggle_count_next       = '0;
          blink_target_next       = blink_finite ? blink_count : 15'd0;
          ticks_since_toggle_next = '0;
          mode_next               = MODE_BLINK;
          kind                    = go_fast ? EV_FAST : EV_SLOW;
          data                    = blink_finite ? blink_count : 15'd0;
        end else if (mode == MODE_BLINK && !blink_finite && !blink_is_finite &&
                     blink_fast != go_fast) begin
          // speed change of an endless blink
          blink_fast_next = go_fast;
          kind            = go_fast ? EV_FAST : EV_SLOW;
        end
      end
      FUNC_STOP: begin
        if (mode == MODE_BLINK) begin
          mode_next  = mode_before_blink ? MODE_ON : MODE_OFF;
          level_next = mode_before_blink;
          kind       = EV_END;
          data       = half;
        end
      end
      default: begin
      end
    endcase

    step.two = two;
    if (two) begin
      step.first = '{led_level: level_next, led_mode: mode_next, event_kind: EV_END,
                     event_data: half, last: 1'b0};
    end else begin
      step.first = '{led_level: level_next, led_mode: mode_next, event_kind: kind,
                     event_data: data, last: 1'b1};
    end
    step.second = '{led_level: level_next, led_mode: mode_next, event_kind: kind,
                    event_data: data, last: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_OFF;
      mode_before_blink  <= 1'b0;
      level              <= 1'b0;
      blink_fast         <= 1'b0;
      blink_is_finite    <= 1'b0;
      toggle_count       <= '0;
      blink_target       <= '0;
      ticks_since_toggle <= '0;
    end else if (valid) begin
      mode               <= mode_next;
      mode_before_blink  <= mode_before_blink_next;
      level              <= level_next;
      blink_fast         <= blink_fast_next;
      blink_is_finite    <= blink_is_finite_next;
      toggle_count       <= toggle_count_next;
      blink_target       <= blink_target_next;
      ticks_since_toggle <= ticks_since_toggle_next;
    end
  end

endmodule

/* hdl/lbc_queue.sv */
`timescale 1ns / 1ps

module lbc_queue import lbc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  step_t   step,
  input  logic    pop,
  output result_t head,
  output logic    not_empty,
  output logic    room
);

  result_t     entries [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic [2:0]  count_next;
  logic [2:0]  n_push;

  assign n_push     = push ? (step.two ? 3'd2 : 3'd1) : 3'd0;
  assign count_next = count + n_push - {2'b00, pop};
  assign head       = entries[rd_ptr];
  assign not_empty  = (count != 3'd0);
  // room for the worst case of two results from one item
  assign room       = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= step.first;
      if (step.two) begin
        entries[wr_ptr + 2'd1] <= step.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[1:0];
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

endmodule

/* hdl/led_blink_controller_core.sv */
`timescale 1ns / 1ps

// Channel   Dir  Contents
// s_*       in   tdata: blink_count[14:0]; tuser: func[3:0], blink_finite[4]
// m_*       out  tdata: led_level[0], led_mode[2:1], event_data[17:3]
//                tuser: event_kind; tlast: last result of an item
// APB       in   0x0 slow_interval_ms, 0x4 fast_interval_ms (bits 15:0)
//
// One item per cycle while the queue has room: the state update and the result are worked out in a
// single pass and written into a four-entry result queue.
// On or off during a blink puts two results in the queue, which then takes
// two output transfers.
// s_tready is high while the queue has room for two results.
// Reset is synchronous; state returns to off, queue empties.

module led_blink_controller_core import lbc_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // blink_count[14:0], zero pad[15]
  input  logic [4:0]  s_tuser,   // func[3:0], blink_finite[4]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // led_level[0], led_mode[2:1], event_data[17:3], pad
  output logic [2:0]  m_tuser,   // event_kind[2:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] slow_interval_ms;
  logic [15:0] fast_interval_ms;
  logic        cfg_write;
  logic        in_xfer;
  logic        out_xfer;
  step_t       step;
  result_t     head;
  logic        room;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {16'd0, (paddr[2] == REG_FAST) ? fast_interval_ms : slow_interval_ms};

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_interval_ms <= SLOW_RESET;
      fast_interval_ms <= FAST_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SLOW) begin
        slow_interval_ms <= pwdata[15:0];
      end else begin
        fast_interval_ms <= pwdata[15:0];
      end
    end
  end

  assign s_tready = room;
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  lbc_fsm #(
    .COUNT_BITS (COUNT_BITS)
  ) u_fsm (
    .clk              (clk),
    .rst              (rst),
    .valid            (in_xfer),
    .func             (s_tuser[3:0]),
    .blink_finite     (s_tuser[4]),
    .blink_count      (s_tdata[14:0]),
    .slow_interval_ms (slow_interval_ms),
    .fast_interval_ms (fast_interval_ms),
    .step             (step)
  );

  lbc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_xfer),
    .step      (step),
    .pop       (out_xfer),
    .head      (head),
    .not_empty (m_tvalid),
    .room      (room)
  );

  assign m_tdata = {6'd0, head.event_data, head.led_mode, head.led_level};
  assign m_tuser = head.event_kind;
  assign m_tlast = head.last;

endmodule

/* hdl/lbc_checker.sv */
`timescale 1ns / 1ps
`include "led_blink_controller_core_assert.svh"

module lbc_checker import lbc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [4:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // every accepted item leaves at least one result behind
  `LBC_ASSERT_NEXT(a_in_gives_out, clk, rst, s_tvalid && s_tready, m_tvalid, "item left no result")
  // only a blink end can precede a second result of the same item
  `LBC_ASSERT_SAME(a_first_is_end, clk, rst, m_tvalid && !m_tlast, m_tuser == EV_END, "non-final result is not a blink end")
  // the second result of a pair is already waiting
  `LBC_ASSERT_NEXT(a_pair_follows, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid, "second result missing")
  // level is low while the mode is inactive or off
  `LBC_ASSERT_SAME(a_level_mode, clk, rst, m_tvalid && (m_tdata[2:1] == MODE_INACTIVE || m_tdata[2:1] == MODE_OFF), m_tdata[0] == 1'b0, "LED lit while off or inactive")
  // a stalled result holds
  `LBC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind led_blink_controller_core lbc_checker u_lbc_checker (.*);
